// ===== design/c8core_pkg.sv =====
package c8core_pkg;

    localparam int unsigned MEM_BYTES = 4096;
    localparam int unsigned FONT_BASE = 12'h050;
    localparam int unsigned FONT_BYTES = 80;
    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_EXEC  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_STACK_FULL = 2'd1,
        ST_STACK_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [7:0]  data;
        logic [4:0]  row;
    } in_item_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] opcode;
        logic [11:0] index_value;
        logic [7:0]  flag_value;
        logic [63:0] row_pixels;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_EXEC,
        S_DRAW_RD,
        S_DRAW_WR,
        S_CLS,
        S_DISP_RD,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear_step;     // write one reset word of memory per cycle
        logic mem_write;      // host byte write
        logic mem_rd_pc;      // read memory at PC
        logic mem_rd_pc1;     // read memory at PC+1, latch high byte
        logic latch_lo;       // latch low byte
        logic exec;           // execute non-draw part of opcode
        logic draw_init;
        logic draw_wr;        // xor back
        logic cls_step;
        logic disp_rd;
        logic load_out;
        logic [1:0] kind;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
        logic is_draw;
        logic is_cls;
        logic draw_last;
        logic cls_last;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] f;
        case (i)
            7'd0: f = 8'hF0; 7'd1: f = 8'h90; 7'd2: f = 8'h90; 7'd3: f = 8'h90;
            7'd4: f = 8'hF0; 7'd5: f = 8'h20; 7'd6: f = 8'h60; 7'd7: f = 8'h20;
            7'd8: f = 8'h20; 7'd9: f = 8'h70; 7'd10: f = 8'hF0; 7'd11: f = 8'h10;
            7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
            7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
            7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
            7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
            7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
            7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
            7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
            7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
            7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
            7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
            7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
            7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
            7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
            7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
            7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
            7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
            7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

// ===== design/c8core_ctrl.sv =====
module c8core_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_kind,
    output logic                out_valid,
    input  logic                out_ready,
    input  c8core_pkg::stat_t   stat,
    output c8core_pkg::ctrl_t   ctrl
);

    c8core_pkg::state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= c8core_pkg::S_CLEAR;
            kind_reg   <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        ovalid_next = ovalid_reg;
        in_ready    = 1'b0;
        ctrl        = '0;
        ctrl.kind   = kind_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            c8core_pkg::S_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = c8core_pkg::S_IDLE;
                end
            end
            c8core_pkg::S_IDLE:
            begin
                in_ready = !ovalid_reg;
                if (in_valid && !ovalid_reg)
                begin
                    kind_next = in_kind;
                    unique case (in_kind)
                        c8core_pkg::KIND_WRITE:
                        begin
                            ctrl.mem_write = 1'b1;
                            state_next = c8core_pkg::S_DONE;
                        end
                        c8core_pkg::KIND_EXEC:
                        begin
                            ctrl.mem_rd_pc = 1'b1;
                            state_next = c8core_pkg::S_FETCH_HI;
                        end
                        c8core_pkg::KIND_READ:
                        begin
                            ctrl.disp_rd = 1'b1;
                            state_next = c8core_pkg::S_DISP_RD;
                        end
                        default:
                        begin
                            state_next = c8core_pkg::S_DONE;
                        end
                    endcase
                end
            end
            c8core_pkg::S_FETCH_HI:
            begin
                ctrl.mem_rd_pc1 = 1'b1;
                state_next = c8core_pkg::S_FETCH_LO;
            end
            c8core_pkg::S_FETCH_LO:
            begin
                ctrl.latch_lo = 1'b1;
                state_next = c8core_pkg::S_EXEC;
            end
            c8core_pkg::S_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (stat.is_draw)
                begin
                    ctrl.draw_init = 1'b1;
                    state_next = c8core_pkg::S_DRAW_RD;
                end
                else if (stat.is_cls)
                begin
                    state_next = c8core_pkg::S_CLS;
                end
                else
                begin
                    state_next = c8core_pkg::S_DONE;
                end
            end
            c8core_pkg::S_DRAW_RD:
            begin
                if (stat.draw_last)
                begin
                    state_next = c8core_pkg::S_DONE;
                end
                else
                begin
                    state_next = c8core_pkg::S_DRAW_WR;
                end
            end
            c8core_pkg::S_DRAW_WR:
            begin
                ctrl.draw_wr = 1'b1;
                state_next = c8core_pkg::S_DRAW_RD;
            end
            c8core_pkg::S_CLS:
            begin
                ctrl.cls_step = 1'b1;
                if (stat.cls_last)
                begin
                    state_next = c8core_pkg::S_DONE;
                end
            end
            c8core_pkg::S_DISP_RD:
            begin
                state_next = c8core_pkg::S_DONE;
            end
            c8core_pkg::S_DONE:
            begin
                ctrl.load_out = 1'b1;
                ovalid_next = 1'b1;
                state_next = c8core_pkg::S_IDLE;
            end
            default:
            begin
                state_next = c8core_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/c8core_dp.sv =====
module c8core_dp
#(
    parameter int unsigned STACK_ENTRIES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  c8core_pkg::in_item_t   in_data,
    input  c8core_pkg::ctrl_t      ctrl,
    output c8core_pkg::stat_t      stat,
    output c8core_pkg::out_item_t  out_data
);

    localparam int unsigned SP_W = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int unsigned SD_W = $clog2(STACK_ENTRIES + 1);

    logic [7:0]  mem [c8core_pkg::MEM_BYTES];
    logic [7:0]  mem_q;
    logic [11:0] mem_raddr;
    logic [63:0] disp [32];
    logic [63:0] disp_q;
    logic [4:0]  disp_raddr;
    logic [11:0] stack [STACK_ENTRIES];
    logic [11:0] stack_q;

    logic [7:0]  v_reg [16];
    logic [11:0] pc_reg, i_reg;
    logic [SD_W-1:0] sd_reg;
    logic [11:0] clr_reg;
    logic [7:0]  op_hi_reg;
    logic [15:0] op_reg;
    logic [4:0]  row_reg;
    logic [3:0]  drow_reg;
    logic [5:0]  x0_reg;
    logic [4:0]  y_reg;
    logic        hit_reg;
    logic [1:0]  st_reg;
    logic [4:0]  cls_reg;
    c8core_pkg::out_item_t out_reg;

    logic [3:0]  opx, opy, opn;
    logic [7:0]  vx, vy, nn;
    logic [63:0] bits;
    logic [11:0] wr_addr;
    logic [7:0]  wr_data;
    logic        wr_en;

    assign opx = op_reg[11:8];
    assign opy = op_reg[7:4];
    assign opn = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign vx  = v_reg[opx];
    assign vy  = v_reg[opy];
    assign bits = {mem_q, 56'd0} >> x0_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = in_data.address;
        wr_data = in_data.data;
        if (ctrl.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[11:0];
            wr_data = 8'h00;
            if (clr_reg[11:0] >= 12'(c8core_pkg::FONT_BASE)
                && clr_reg[11:0] < 12'(c8core_pkg::FONT_BASE + c8core_pkg::FONT_BYTES))
            begin
                wr_data = c8core_pkg::font_byte(7'(clr_reg[11:0] - 12'(c8core_pkg::FONT_BASE)));
            end
        end
        else if (ctrl.mem_write)
        begin
            wr_en = 1'b1;
        end
        mem_raddr = i_reg + 12'(drow_reg);
        if (ctrl.mem_rd_pc)
        begin
            mem_raddr = pc_reg;
        end
        else if (ctrl.mem_rd_pc1)
        begin
            mem_raddr = pc_reg + 12'd1;
        end
        // A row read keeps its row address until the result is loaded.
        if (ctrl.disp_rd)
        begin
            disp_raddr = in_data.row;
        end
        else if (ctrl.kind == c8core_pkg::KIND_READ)
        begin
            disp_raddr = row_reg;
        end
        else
        begin
            disp_raddr = y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[mem_raddr];
        disp_q <= disp[disp_raddr];
        stack_q <= stack[SP_W'(sd_reg - SD_W'(1))];
        if (ctrl.exec && op_reg[15:12] == 4'h2 && sd_reg < SD_W'(STACK_ENTRIES))
        begin
            stack[sd_reg[SP_W-1:0]] <= pc_reg;
        end
        if (ctrl.disp_rd)
        begin
            row_reg <= in_data.row;
        end
    end

    // Display writes: clear sweep or sprite XOR.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 32; k++)
            begin
                disp[k] <= '0;
            end
        end
        else if (ctrl.cls_step)
        begin
            disp[cls_reg] <= '0;
        end
        else if (ctrl.draw_wr)
        begin
            disp[y_reg] <= disp_q ^ bits;
        end
    end

    assign stat.clear_done = clr_reg[11:0] == 12'hFFF;
    assign stat.is_draw    = op_reg[15:12] == 4'hD;
    assign stat.is_cls     = op_reg == 16'h00E0;
    assign stat.draw_last  = drow_reg == opn || y_reg == 5'd0 && drow_reg != 4'd0;
    assign stat.cls_last   = cls_reg == 5'd31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'd0;
            end
            pc_reg   <= c8core_pkg::PC_RESET;
            i_reg    <= 12'd0;
            sd_reg   <= '0;
            clr_reg  <= '0;
            op_reg   <= 16'd0;
            op_hi_reg <= 8'd0;
            drow_reg <= 4'd0;
            x0_reg   <= 6'd0;
            y_reg    <= 5'd0;
            hit_reg  <= 1'b0;
            st_reg   <= c8core_pkg::ST_OK;
            cls_reg  <= 5'd0;
            out_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear_step)
            begin
                clr_reg <= clr_reg + 12'd1;
            end
            if (ctrl.mem_rd_pc)
            begin
                st_reg  <= c8core_pkg::ST_OK;
            end
            if (ctrl.mem_rd_pc1)
            begin
                op_hi_reg <= mem_q;
            end
            if (ctrl.latch_lo)
            begin
                op_reg <= {op_hi_reg, mem_q};
                pc_reg <= pc_reg + 12'd2;
            end
            if (ctrl.exec)
            begin
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00EE)
                        begin
                            if (sd_reg == '0)
                            begin
                                st_reg <= c8core_pkg::ST_STACK_EMPTY;
                            end
                            else
                            begin
                                // stack_q already holds the top entry here.
                                sd_reg <= sd_reg - SD_W'(1);
                                pc_reg <= stack_q;
                            end
                        end
                    end
                    4'h1: pc_reg <= op_reg[11:0];
                    4'h2:
                    begin
                        if (sd_reg >= SD_W'(STACK_ENTRIES))
                        begin
                            st_reg <= c8core_pkg::ST_STACK_FULL;
                        end
                        else
                        begin
                            sd_reg <= sd_reg + SD_W'(1);
                            pc_reg <= op_reg[11:0];
                        end
                    end
                    4'h3: if (vx == nn) pc_reg <= pc_reg + 12'd2;
                    4'h4: if (vx != nn) pc_reg <= pc_reg + 12'd2;
                    4'h5: if (opn == 4'd0 && vx == vy) pc_reg <= pc_reg + 12'd2;
                    4'h9: if (opn == 4'd0 && vx != vy) pc_reg <= pc_reg + 12'd2;
                    4'h6: v_reg[opx] <= nn;
                    4'h7: v_reg[opx] <= vx + nn;
                    4'h8:
                    begin
                        // For the add and subtract forms, when VF is the target, only the flag is kept.
                        case (opn)
                            4'h0: v_reg[opx] <= vy;
                            4'h1: v_reg[opx] <= vx | vy;
                            4'h2: v_reg[opx] <= vx & vy;
                            4'h3: v_reg[opx] <= vx ^ vy;
                            4'h4:
                            begin
                                if (opx != 4'hF)
                                begin
                                    v_reg[opx] <= vx + vy;
                                end
                                v_reg[15]  <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                            end
                            4'h5:
                            begin
                                if (opx != 4'hF)
                                begin
                                    v_reg[opx] <= vx - vy;
                                end
                                v_reg[15]  <= {7'd0, vx >= vy};
                            end
                            4'h7:
                            begin
                                if (opx != 4'hF)
                                begin
                                    v_reg[opx] <= vy - vx;
                                end
                                v_reg[15]  <= {7'd0, vy >= vx};
                            end
                            default: ;
                        endcase
                    end
                    4'hA: i_reg <= op_reg[11:0];
                    default: ;
                endcase
            end
            if (ctrl.draw_init)
            begin
                drow_reg <= 4'd0;
                x0_reg   <= vx[5:0];
                y_reg    <= vy[4:0];
                hit_reg  <= 1'b0;
            end
            if (ctrl.draw_wr)
            begin
                if ((disp_q & bits) != '0)
                begin
                    hit_reg <= 1'b1;
                end
                drow_reg <= drow_reg + 4'd1;
                y_reg    <= y_reg + 5'd1;
            end
            if (ctrl.cls_step)
            begin
                cls_reg <= cls_reg + 5'd1;
            end
            if (ctrl.load_out)
            begin
                out_reg.program_counter <= pc_reg;
                out_reg.opcode      <= (ctrl.kind == c8core_pkg::KIND_EXEC) ? op_reg : 16'd0;
                out_reg.index_value <= i_reg;
                out_reg.row_pixels  <= (ctrl.kind == c8core_pkg::KIND_READ) ? disp_q : 64'd0;
                out_reg.status      <= (ctrl.kind == c8core_pkg::KIND_EXEC) ? st_reg
                                                                         : c8core_pkg::ST_OK;
                if (ctrl.kind == c8core_pkg::KIND_EXEC && stat.is_draw)
                begin
                    v_reg[15] <= {7'd0, hit_reg};
                    out_reg.flag_value <= {7'd0, hit_reg};
                end
                else
                begin
                    out_reg.flag_value <= v_reg[15];
                end
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ===== design/chip8_instruction_core.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (kind, address, data, row)
// out     | output    | out_valid / out_ready | out_data (pc, opcode, index, flag, pixels, status)
//
// After reset a clearing pass loads the font and zeroes the rest of main
// memory; no item is taken until it ends.
// A clear-screen instruction clears one display row per cycle. In a sprite
// draw each row needs one memory port read and one display read-modify-write,
// and rows below the bottom edge are skipped.
// One item is in work at a time; a new transfer is taken once the previous
// result has been transferred out.
module chip8_instruction_core
#(
    parameter int unsigned STACK_ENTRIES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  c8core_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output c8core_pkg::out_item_t  out_data
);

    c8core_pkg::ctrl_t ctrl;
    c8core_pkg::stat_t stat;

    // Sequencer for fetch, execute, draw and clear.
    c8core_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (in_data.kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Machine state, memories and the result register.
    c8core_dp #(.STACK_ENTRIES(STACK_ENTRIES)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .ctrl     (ctrl),
        .stat     (stat),
        .out_data (out_data)
    );

    // Input is never taken while a result is waiting.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    // Status holds one of the defined codes; it is only nonzero for execute results.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == c8core_pkg::ST_OK
                       || out_data.status == c8core_pkg::ST_STACK_FULL
                       || out_data.status == c8core_pkg::ST_STACK_EMPTY))
        else $error("bad status");

    // Non-read results carry no pixels; checked here for results with a nonzero opcode.
    a_opcode_kind: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && out_data.opcode != 16'd0 |-> out_data.row_pixels == 64'd0)
        else $error("pixels on execute result");

endmodule
